/* sv/dsv_pkg.sv */
// ----------------------------------------------------------------------------
// dsv_pkg
// Shared types and constants for the DSA sign/verify engine.
// ----------------------------------------------------------------------------
package dsv_pkg;

  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRIME_P     = 3'd0,
    REG_ORDER_Q     = 3'd1,
    REG_GENERATOR_G = 3'd2,
    REG_PRIVATE_KEY = 3'd3,
    REG_PUBLIC_KEY  = 3'd4
  } cfg_reg_e;

  localparam logic [CfgDataW-1:0] PrimePRst     = 32'd23;
  localparam logic [CfgDataW-1:0] OrderQRst     = 32'd11;
  localparam logic [CfgDataW-1:0] GeneratorGRst = 32'd5;
  localparam logic [CfgDataW-1:0] PrivateKeyRst = 32'd0;
  localparam logic [CfgDataW-1:0] PublicKeyRst  = 32'd1;

  localparam logic FuncSign   = 1'b0;
  localparam logic FuncVerify = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MP_START,
    ST_MP_BRED,
    ST_MP_LOOP,
    ST_MP_ACC,
    ST_MP_SQR,
    ST_SG_R,
    ST_SG_R_W,
    ST_SG_T,
    ST_SG_T_W,
    ST_SG_H_W,
    ST_SG_S,
    ST_SG_S_W,
    ST_VF_U1,
    ST_VF_U1_W,
    ST_VF_U2_W,
    ST_VF_A,
    ST_VF_B,
    ST_VF_V_W,
    ST_VF_VQ_W,
    ST_OUT
  } state_e;

endpackage

/* sv/dsv_in_if.sv */
// ----------------------------------------------------------------------------
// dsv_in_if
// Request channel: operation select, hash byte, nonce and signature parts.
// ----------------------------------------------------------------------------
interface dsv_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  hash_byte;
  logic [31:0] nonce;
  logic [31:0] in_r;
  logic [31:0] in_s;

  modport source (output valid, func, hash_byte, nonce, in_r, in_s, input ready);
  modport sink   (input valid, func, hash_byte, nonce, in_r, in_s, output ready);
endinterface

/* sv/dsv_out_if.sv */
// ----------------------------------------------------------------------------
// dsv_out_if
// Result channel: signature r, s and the verify flag.
// ----------------------------------------------------------------------------
interface dsv_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_r;
  logic [31:0] out_s;
  logic        valid_res;

  modport source (output valid, out_r, out_s, valid_res, input ready);
  modport sink   (input valid, out_r, out_s, valid_res, output ready);
endinterface

/* sv/dsa_sign_verify_engine_core.sv */
// ----------------------------------------------------------------------------
// dsa_sign_verify_engine_core
// Small-modulus DSA sign and verify on one shared modular multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Load p, q, g, x and y through the write port (cfg_we_i, cfg_idx_i,
//   cfg_data_i) while the engine is idle. Each request transaction on in_i
//   selects sign (func 0: r, s from nonce k) or verify (func 1: checks in_r,
//   in_s against y). Exactly one result transaction follows on out_o.
// Datapath:
//   All work runs through one bit-serial mod-multiplier. A modular
//   exponentiation costs about 2*MOD_WIDTH products (fewer for short
//   exponents), and verify runs one more exponentiation than sign.
//   Rejected signatures skip the multiplier and go to the result. One request
//   is in flight at a time; in_i.ready is high only while idle.
// Reset:
//   Registers return to p=23, q=11, g=5, x=0, y=1; the sequencer goes idle.
// Stall:
//   The result is held in output registers until out_o.ready; no new
//   request is taken before the result transaction completes.
// ----------------------------------------------------------------------------
module dsa_sign_verify_engine_core
  import dsv_pkg::*;
#(
  parameter int unsigned MOD_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  dsv_in_if.sink              in_i,
  dsv_out_if.source           out_o
);

  localparam int unsigned W    = MOD_WIDTH;
  localparam int unsigned CntW = $clog2(W + 1);

  // configuration
  logic [W-1:0] p_q, q_q, g_q, x_q, y_q;

  // request
  logic         func_q;
  logic [7:0]   h_q;
  logic [W-1:0] k_q, rin_q, sin_q;

  // sequencer / work registers
  state_e       state_q, state_d, ret_q, ret_d;
  logic [W-1:0] mp_base_q, mp_base_d, mp_exp_q, mp_exp_d;
  logic [W-1:0] mp_acc_q, mp_acc_d, mp_mod_q, mp_mod_d;
  logic [W-1:0] r_q, r_d, w_q, w_d, t_q, t_d, u2_q, u2_d, a_q, a_d;
  logic [W-1:0] out_r_q, out_r_d, out_s_q, out_s_d;
  logic         out_v_q, out_v_d;

  // shared mod-multiplier
  logic         mm_start;
  logic [W-1:0] mm_xn, mm_bn, mm_mn;
  logic [W-1:0] mm_x_q, mm_b_q, mm_m_q, mm_acc_q;
  logic [CntW-1:0] mm_cnt_q;
  logic         mm_busy_q, mm_done_q;
  logic [W+1:0] mm_sum, mm_s1, mm_s2;

  logic [W-1:0] qm2;
  logic [W:0]   addq;
  logic         bad_sig;

  assign qm2 = q_q - W'(2);

  // configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= PrimePRst[W-1:0];
      q_q <= OrderQRst[W-1:0];
      g_q <= GeneratorGRst[W-1:0];
      x_q <= PrivateKeyRst[W-1:0];
      y_q <= PublicKeyRst[W-1:0];
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PRIME_P:     p_q <= cfg_data_i[W-1:0];
        REG_ORDER_Q:     q_q <= cfg_data_i[W-1:0];
        REG_GENERATOR_G: g_q <= cfg_data_i[W-1:0];
        REG_PRIVATE_KEY: x_q <= cfg_data_i[W-1:0];
        REG_PUBLIC_KEY:  y_q <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  // Mod-multiplier: acc = (2*acc + xbit*b) mod m, MSB first.
  // Needs acc, b < m, so the sum stays below 3m; two conditional subtracts.
  assign mm_sum = {1'b0, mm_acc_q, 1'b0} + (mm_x_q[W-1] ? {2'b00, mm_b_q} : '0);
  assign mm_s1  = (mm_sum >= {2'b00, mm_m_q}) ? mm_sum - {2'b00, mm_m_q} : mm_sum;
  assign mm_s2  = (mm_s1 >= {2'b00, mm_m_q}) ? mm_s1 - {2'b00, mm_m_q} : mm_s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_busy_q <= 1'b0;
      mm_done_q <= 1'b0;
      mm_cnt_q  <= '0;
    end else begin
      mm_done_q <= 1'b0;
      if (mm_start) begin
        mm_busy_q <= 1'b1;
        mm_cnt_q  <= CntW'(W);
      end else if (mm_busy_q) begin
        mm_cnt_q <= mm_cnt_q - CntW'(1);
        if (mm_cnt_q == CntW'(1)) begin
          mm_busy_q <= 1'b0;
          mm_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mm_start) begin
      mm_x_q   <= mm_xn;
      mm_b_q   <= mm_bn;
      mm_m_q   <= mm_mn;
      mm_acc_q <= '0;
    end else if (mm_busy_q) begin
      mm_x_q   <= {mm_x_q[W-2:0], 1'b0};
      mm_acc_q <= mm_s2[W-1:0];
    end
  end

  assign bad_sig = (in_i.in_r[W-1:0] == '0) || (in_i.in_r[W-1:0] >= q_q) ||
                   (in_i.in_s[W-1:0] == '0) || (in_i.in_s[W-1:0] >= q_q);
  assign addq    = {1'b0, mm_acc_q} + {1'b0, t_q};

  // sequencer
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    mp_base_d = mp_base_q;
    mp_exp_d  = mp_exp_q;
    mp_acc_d  = mp_acc_q;
    mp_mod_d  = mp_mod_q;
    r_d       = r_q;
    w_d       = w_q;
    t_d       = t_q;
    u2_d      = u2_q;
    a_d       = a_q;
    out_r_d   = out_r_q;
    out_s_d   = out_s_q;
    out_v_d   = out_v_q;
    mm_start  = 1'b0;
    mm_xn     = '0;
    mm_bn     = '0;
    mm_mn     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          out_r_d = '0;
          out_s_d = '0;
          out_v_d = 1'b0;
          if (in_i.func == FuncSign) begin
            if (q_q < W'(2)) begin
              state_d = ST_OUT;
            end else begin
              mp_base_d = g_q;
              mp_exp_d  = in_i.nonce[W-1:0];
              mp_mod_d  = p_q;
              ret_d     = ST_SG_R;
              state_d   = ST_MP_START;
            end
          end else begin
            if (bad_sig) begin
              state_d = ST_OUT;
            end else begin
              mp_base_d = in_i.in_s[W-1:0];
              mp_exp_d  = qm2;
              mp_mod_d  = q_q;
              ret_d     = ST_VF_U1;
              state_d   = ST_MP_START;
            end
          end
        end
      end

      // modular exponentiation subroutine, result in mp_acc
      ST_MP_START: begin
        mp_acc_d = W'(1);
        if (mp_mod_q < W'(2)) begin
          mp_acc_d = '0;
          state_d  = ret_q;
        end else begin
          mm_start = 1'b1;
          mm_xn    = mp_base_q;
          mm_bn    = W'(1);
          mm_mn    = mp_mod_q;
          state_d  = ST_MP_BRED;
        end
      end
      ST_MP_BRED: begin
        if (mm_done_q) begin
          mp_base_d = mm_acc_q;
          state_d   = ST_MP_LOOP;
        end
      end
      ST_MP_LOOP: begin
        mm_mn = mp_mod_q;
        if (mp_exp_q == '0) begin
          state_d = ret_q;
        end else if (mp_exp_q[0]) begin
          mm_start = 1'b1;
          mm_xn    = mp_acc_q;
          mm_bn    = mp_base_q;
          state_d  = ST_MP_ACC;
        end else begin
          mm_start = 1'b1;
          mm_xn    = mp_base_q;
          mm_bn    = mp_base_q;
          state_d  = ST_MP_SQR;
        end
      end
      ST_MP_ACC: begin
        if (mm_done_q) begin
          mp_acc_d = mm_acc_q;
          mm_start = 1'b1;
          mm_xn    = mp_base_q;
          mm_bn    = mp_base_q;
          mm_mn    = mp_mod_q;
          state_d  = ST_MP_SQR;
        end
      end
      ST_MP_SQR: begin
        if (mm_done_q) begin
          mp_base_d = mm_acc_q;
          mp_exp_d  = mp_exp_q >> 1;
          state_d   = ST_MP_LOOP;
        end
      end

      // sign
      ST_SG_R: begin
        mm_start = 1'b1;
        mm_xn    = mp_acc_q;
        mm_bn    = W'(1);
        mm_mn    = q_q;
        state_d  = ST_SG_R_W;
      end
      ST_SG_R_W: begin
        if (mm_done_q) begin
          r_d       = mm_acc_q;
          mp_base_d = k_q;
          mp_exp_d  = qm2;
          mp_mod_d  = q_q;
          ret_d     = ST_SG_T;
          state_d   = ST_MP_START;
        end
      end
      ST_SG_T: begin
        w_d      = mp_acc_q;  // nonce inverse
        mm_start = 1'b1;
        mm_xn    = x_q;
        mm_bn    = r_q;
        mm_mn    = q_q;
        state_d  = ST_SG_T_W;
      end
      ST_SG_T_W: begin
        if (mm_done_q) begin
          t_d      = mm_acc_q;
          mm_start = 1'b1;
          mm_xn    = W'(h_q);
          mm_bn    = W'(1);
          mm_mn    = q_q;
          state_d  = ST_SG_H_W;
        end
      end
      ST_SG_H_W: begin
        if (mm_done_q) begin
          t_d     = (addq >= {1'b0, q_q}) ? W'(addq - {1'b0, q_q}) : addq[W-1:0];
          state_d = ST_SG_S;
        end
      end
      ST_SG_S: begin
        mm_start = 1'b1;
        mm_xn    = t_q;
        mm_bn    = w_q;
        mm_mn    = q_q;
        state_d  = ST_SG_S_W;
      end
      ST_SG_S_W: begin
        if (mm_done_q) begin
          out_r_d = r_q;
          out_s_d = mm_acc_q;
          state_d = ST_OUT;
        end
      end

      // verify
      ST_VF_U1: begin
        w_d      = mp_acc_q;
        mm_start = 1'b1;
        mm_xn    = W'(h_q);
        mm_bn    = mp_acc_q;
        mm_mn    = q_q;
        state_d  = ST_VF_U1_W;
      end
      ST_VF_U1_W: begin
        if (mm_done_q) begin
          t_d      = mm_acc_q;  // u1
          mm_start = 1'b1;
          mm_xn    = rin_q;
          mm_bn    = w_q;
          mm_mn    = q_q;
          state_d  = ST_VF_U2_W;
        end
      end
      ST_VF_U2_W: begin
        if (mm_done_q) begin
          u2_d = mm_acc_q;
          if (p_q < W'(2)) begin
            state_d = ST_OUT;
          end else begin
            mp_base_d = g_q;
            mp_exp_d  = t_q;
            mp_mod_d  = p_q;
            ret_d     = ST_VF_A;
            state_d   = ST_MP_START;
          end
        end
      end
      ST_VF_A: begin
        a_d       = mp_acc_q;
        mp_base_d = y_q;
        mp_exp_d  = u2_q;
        mp_mod_d  = p_q;
        ret_d     = ST_VF_B;
        state_d   = ST_MP_START;
      end
      ST_VF_B: begin
        mm_start = 1'b1;
        mm_xn    = a_q;
        mm_bn    = mp_acc_q;
        mm_mn    = p_q;
        state_d  = ST_VF_V_W;
      end
      ST_VF_V_W: begin
        if (mm_done_q) begin
          mm_start = 1'b1;
          mm_xn    = mm_acc_q;
          mm_bn    = W'(1);
          mm_mn    = q_q;
          state_d  = ST_VF_VQ_W;
        end
      end
      ST_VF_VQ_W: begin
        if (mm_done_q) begin
          out_v_d = (mm_acc_q == rin_q);
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) begin
      func_q <= in_i.func;
      h_q    <= in_i.hash_byte;
      k_q    <= in_i.nonce[W-1:0];
      rin_q  <= in_i.in_r[W-1:0];
      sin_q  <= in_i.in_s[W-1:0];
    end
    mp_base_q <= mp_base_d;
    mp_exp_q  <= mp_exp_d;
    mp_acc_q  <= mp_acc_d;
    mp_mod_q  <= mp_mod_d;
    r_q       <= r_d;
    w_q       <= w_d;
    t_q       <= t_d;
    u2_q      <= u2_d;
    a_q       <= a_d;
    out_r_q   <= out_r_d;
    out_s_q   <= out_s_d;
    out_v_q   <= out_v_d;
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = (state_q == ST_OUT);
  assign out_o.out_r     = CfgDataW'(out_r_q);
  assign out_o.out_s     = CfgDataW'(out_s_q);
  // the stored s is only read back on verify; func is kept for the result flag
  assign out_o.valid_res = out_v_q & (func_q == FuncVerify) & (sin_q != '0);

endmodule

/* sim/tb_dsa_sign_verify_engine_core.sv */
// ----------------------------------------------------------------------------
// tb_dsa_sign_verify_engine_core
// Self-checking bench for the DSA sign/verify engine. It walks several
// domain settings: the reset values, small real DSA groups, degenerate and
// all-ones moduli, and a large prime. Each request transaction's result is
// predicted or typed in the bench, and each result transaction is checked in order.
// ----------------------------------------------------------------------------
module tb_dsa_sign_verify_engine_core;
  import dsv_pkg::*;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [31:0] r;
    logic [31:0] s;
    logic        ok;
  } sig_res_t;

  // Directed row: the expected result is typed in only where known_exp is set.
  typedef struct packed {
    logic        func;
    logic [7:0]  h;
    logic [31:0] k;
    logic [31:0] r;
    logic [31:0] s;
    logic        known_exp;
    sig_res_t    res;
  } req_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  cfg_reg_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  dsv_in_if  req_if ();
  dsv_out_if rsp_if ();

  dsa_sign_verify_engine_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (req_if),
    .out_o      (rsp_if)
  );

  // Bench copy of the domain registers.
  logic [31:0] dom_p, dom_q, dom_g, key_x, key_y;

  sig_res_t    pending_q[$];
  int unsigned n_err, n_res, n_sign, n_verify, n_good_sig;
  int unsigned cyc;
  bit          no_idle;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  // Square-and-multiply; modulus below 2 collapses to zero.
  function automatic longint unsigned mod_exp(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
    longint unsigned acc;
    if (m < 2) return 0;
    acc = 1;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = (acc * b) % m;
      e = e >> 1;
      b = (b * b) % m;
    end
    return acc;
  endfunction

  function automatic sig_res_t predict_sig(logic func, logic [7:0] h, logic [31:0] k,
                                           logic [31:0] r_in, logic [31:0] s_in);
    sig_res_t        res;
    longint unsigned p, q, ex, kinv, t, w, u1, u2, v;
    p   = dom_p;
    q   = dom_q;
    ex  = (q >= 2) ? q - 2 : 0;
    res = '0;
    if (func == FuncSign) begin
      if (q >= 2) begin
        res.r = 32'(mod_exp(dom_g, k, p) % q);
        kinv  = mod_exp(k, ex, q);
        t     = ((longint'(key_x) % q) * res.r) % q;
        t     = ((longint'(h) % q) + t) % q;
        res.s = 32'((t * kinv) % q);
      end
    end else if (r_in != 0 && r_in < q && s_in != 0 && s_in < q) begin
      w  = mod_exp(s_in, ex, q);
      u1 = ((longint'(h) % q) * w) % q;
      u2 = (longint'(r_in) * w) % q;
      v  = 0;
      if (p >= 2) v = ((mod_exp(dom_g, u1, p) * mod_exp(key_y, u2, p)) % p) % q;
      res.ok = (v == r_in);
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset, timeout
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results pending", cyc, pending_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random ready bursts, in-order checking
  // --------------------------------------------------------------------------
  int unsigned stall_left;

  always @(negedge clk_i) begin
    if (!rst_ni || no_idle) begin
      rsp_if.ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready = 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      rsp_if.ready = 1'b0;
    end else begin
      rsp_if.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    sig_res_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      n_res++;
      if (pending_q.size() == 0) begin
        n_err++;
        if (n_err <= MaxReports)
          $display("Unexpected result transaction: r=%0d s=%0d ok=%0b",
                   rsp_if.out_r, rsp_if.out_s, rsp_if.valid_res);
      end else begin
        want = pending_q.pop_front();
        if (rsp_if.out_r !== want.r || rsp_if.out_s !== want.s ||
            rsp_if.valid_res !== want.ok) begin
          n_err++;
          if (n_err <= MaxReports)
            $display("Mismatch at result %0d: exp r=%0d s=%0d ok=%0b got r=%0d s=%0d ok=%0b",
                     n_res, want.r, want.s, want.ok,
                     rsp_if.out_r, rsp_if.out_s, rsp_if.valid_res);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // One request transaction; an idle burst may precede it. The expectation is
  // queued at the accepting edge.
  task automatic send_req(logic func, logic [7:0] h, logic [31:0] k, logic [31:0] r,
                          logic [31:0] s, bit use_exp, sig_res_t given);
    sig_res_t want;
    want = use_exp ? given : predict_sig(func, h, k, r, s);
    @(negedge clk_i);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    req_if.valid     = 1'b1;
    req_if.func      = func;
    req_if.hash_byte = h;
    req_if.nonce     = k;
    req_if.in_r      = r;
    req_if.in_s      = s;
    do @(posedge clk_i); while (!req_if.ready);
    pending_q.push_back(want);
    if (func == FuncSign) n_sign++;
    else n_verify++;
    if (want.ok) n_good_sig++;
  endtask

  // Registers are only touched with the engine idle and nothing outstanding.
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      REG_PRIME_P:     dom_p = val;
      REG_ORDER_Q:     dom_q = val;
      REG_GENERATOR_G: dom_g = val;
      REG_PRIVATE_KEY: key_x = val;
      default:         key_y = val;
    endcase
  endtask

  task automatic load_domain(logic [31:0] p, logic [31:0] q, logic [31:0] g,
                             logic [31:0] x, logic [31:0] y);
    @(negedge clk_i);
    req_if.valid = 1'b0;
    wait (pending_q.size() == 0);
    repeat (4) @(posedge clk_i);
    write_reg(REG_PRIME_P, p);
    write_reg(REG_ORDER_Q, q);
    write_reg(REG_GENERATOR_G, g);
    write_reg(REG_PRIVATE_KEY, x);
    write_reg(REG_PUBLIC_KEY, y);
  endtask

  // Mostly honest sign-then-verify pairs (some tampered), plus raw noise.
  task automatic random_traffic(int unsigned n);
    logic [7:0]  h;
    logic [31:0] k, r, s;
    sig_res_t    sig;
    int unsigned kind;
    repeat (n) begin
      h    = 8'($urandom);
      kind = $urandom_range(0, 9);
      k    = ($urandom_range(0, 3) == 0 || dom_q < 3) ? $urandom()
                                                      : $urandom_range(1, dom_q - 1);
      if (kind < 6) begin
        send_req(FuncSign, h, k, $urandom(), $urandom(), 1'b0, '0);
        sig = predict_sig(FuncSign, h, k, '0, '0);
        r   = sig.r;
        s   = sig.s;
        case (kind)
          4:       h = h ^ 8'(1 << $urandom_range(0, 7));
          5:       s = s + 32'd1;
          default: ;
        endcase
        send_req(FuncVerify, h, $urandom(), r, s, 1'b0, '0);
      end else if (kind < 8) begin
        r = (dom_q > 1) ? $urandom_range(0, dom_q - 1) : $urandom();
        s = (dom_q > 1) ? $urandom_range(0, dom_q - 1) : $urandom();
        send_req(FuncVerify, h, $urandom(), r, s, 1'b0, '0);
      end else begin
        send_req(logic'(kind[0]), h, $urandom(), $urandom(), $urandom(), 1'b0, '0);
      end
    end
  endtask

  // Reset-value domain: p=23, q=11, g=5, x=0, y=1.
  req_row_t dir_rows[] = '{
    // verify with r or s zero / out of range: rejected outright
    '{FuncVerify, 8'd7,   32'd0, 32'd0,          32'd5,          1'b1, '{32'd0, 32'd0, 1'b0}},
    '{FuncVerify, 8'd7,   32'd0, 32'd11,         32'd5,          1'b1, '{32'd0, 32'd0, 1'b0}},
    '{FuncVerify, 8'd7,   32'd0, 32'd3,          32'd0,          1'b1, '{32'd0, 32'd0, 1'b0}},
    '{FuncVerify, 8'd255, 32'd0, 32'd3,          32'd11,         1'b1, '{32'd0, 32'd0, 1'b0}},
    '{FuncVerify, 8'd0,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      1'b1, '{32'd0, 32'd0, 1'b0}},
    // sign with k=0: r = 1, inverse of zero nonce is zero
    '{FuncSign,   8'd0,   32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'd1, 32'd0, 1'b0}},
    // nonce a multiple of q: g^11 mod 23 = 22, 22 mod 11 = 0, and s = 0
    '{FuncSign,   8'd255, 32'd11, 32'd0,        32'd0,          1'b1, '{32'd0, 32'd0, 1'b0}},
    '{FuncSign,   8'd255, 32'hFFFF_FFFF, 32'd0, 32'd0,          1'b0, '0},
    '{FuncSign,   8'd3,   32'd7,  32'd0,        32'd0,          1'b0, '0},
    '{FuncSign,   8'd128, 32'd1,  32'd0,        32'd0,          1'b0, '0},
    '{FuncVerify, 8'd0,   32'd0,  32'd1,        32'd1,          1'b0, '0},
    '{FuncVerify, 8'd255, 32'd0,  32'd10,       32'd10,         1'b0, '0},
    '{FuncVerify, 8'd3,   32'd0,  32'd2,        32'd9,          1'b0, '0},
    '{FuncVerify, 8'd3,   32'd0,  32'd4,        32'd3,          1'b0, '0}
  };

  initial begin
    logic [31:0] g_sel, x_sel;
    n_err      = 0;
    n_res      = 0;
    n_sign     = 0;
    n_verify   = 0;
    n_good_sig = 0;
    cyc        = 0;
    stall_left = 0;
    no_idle    = 1'b0;
    rst_ni     = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = REG_PRIME_P;
    cfg_data   = '0;
    req_if.valid     = 1'b0;
    req_if.func      = FuncSign;
    req_if.hash_byte = '0;
    req_if.nonce     = '0;
    req_if.in_r      = '0;
    req_if.in_s      = '0;
    rsp_if.ready     = 1'b1;
    dom_p = PrimePRst;
    dom_q = OrderQRst;
    dom_g = GeneratorGRst;
    key_x = PrivateKeyRst;
    key_y = PublicKeyRst;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows against the reset domain.
    foreach (dir_rows[i])
      send_req(dir_rows[i].func, dir_rows[i].h, dir_rows[i].k, dir_rows[i].r,
               dir_rows[i].s, dir_rows[i].known_exp, dir_rows[i].res);

    // Real group: 2 has order 11 mod 23, y = 2^7 mod 23.
    load_domain(32'd23, 32'd11, 32'd2, 32'd7, 32'd13);
    random_traffic(10);

    // q = 101 divides 606; g is a sixth power, so its order is 101.
    g_sel = 32'(mod_exp($urandom_range(2, 605), 6, 607));
    if (g_sel < 2) g_sel = 32'd64;
    x_sel = $urandom_range(1, 100);
    load_domain(32'd607, 32'd101, g_sel, x_sel, 32'(mod_exp(g_sel, x_sel, 607)));
    random_traffic(12);

    // Smallest moduli, zero generator and keys.
    load_domain(32'd2, 32'd2, 32'd0, 32'd0, 32'd0);
    random_traffic(4);

    // Every register at all ones.
    load_domain('1, '1, '1, '1, '1);
    random_traffic(3);

    // Largest 32-bit prime for p, 16-bit prime for q.
    g_sel = $urandom();
    x_sel = $urandom();
    load_domain(32'd4294967291, 32'd65521, g_sel, x_sel,
                32'(mod_exp(g_sel, x_sel, 32'd4294967291)));
    random_traffic(6);

    // Closing stretch with both sides running flat out.
    g_sel = 32'(mod_exp($urandom_range(2, 605), 6, 607));
    if (g_sel < 2) g_sel = 32'd64;
    x_sel = $urandom_range(1, 100);
    load_domain(32'd607, 32'd101, g_sel, x_sel, 32'(mod_exp(g_sel, x_sel, 607)));
    no_idle = 1'b1;
    random_traffic(10);

    @(negedge clk_i);
    req_if.valid = 1'b0;
    wait (pending_q.size() == 0);
    repeat (50) @(posedge clk_i);

    $display("Ran %0d sign and %0d verify transactions over seven domain settings,",
             n_sign, n_verify);
    $display("%0d signatures expected valid; %0d results checked, %0d mismatches.",
             n_good_sig, n_res, n_err);
    if (n_err == 0 && pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
